/* hw/rtl/cco_pkg.sv */
// Shared types and constants for the cursor overlay compositor.
// Used by cco_front, cco_queue, cco_back and the top level.
package cco_pkg;

    // Cursor image store
    localparam int IMG_ENTRIES = 256;
    localparam int IMG_AW      = $clog2(IMG_ENTRIES);

    // Screen coordinates
    localparam int COORD_LIMIT = 1024;
    localparam int COORD_W     = 10;
    localparam int SCR_W       = 11;
    localparam int MV_W        = 18;

    // Cursor size
    localparam int CURSOR_MAX = 16;
    localparam int CUR_SW     = 5;
    localparam int CUR_IW     = $clog2(CURSOR_MAX);
    localparam int ASUM_W     = CUR_IW + CUR_SW;

    // Config registers
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 11;
    localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_CURSOR_WIDTH  = 2'd2;
    localparam logic [CFG_IW-1:0] REG_CURSOR_HEIGHT = 2'd3;

    localparam logic [SCR_W-1:0]  SCREEN_WIDTH_RST  = 11'd640;
    localparam logic [SCR_W-1:0]  SCREEN_HEIGHT_RST = 11'd480;
    localparam logic [CUR_SW-1:0] CURSOR_WIDTH_RST  = 5'd10;
    localparam logic [CUR_SW-1:0] CURSOR_HEIGHT_RST = 5'd16;

    // Queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MOVE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EK_PIXEL  = 2'd0,
        EK_LOAD   = 2'd1,
        EK_REPORT = 2'd2
    } ekind_t;

    localparam logic RK_PIXEL  = 1'b0;
    localparam logic RK_REPORT = 1'b1;

    // One classified item between front and back
    typedef struct packed {
        ekind_t               kind;
        logic                 hit;
        logic [IMG_AW-1:0]    addr;
        logic [7:0]           color;   // background color, or image value on a load
        logic [COORD_W-1:0]   cur_x;
        logic [COORD_W-1:0]   cur_y;
        logic                 moved;
    } entry_t;

endpackage

/* hw/rtl/cco_front.sv */
// Front end: config registers, cursor position, item classification.
// Depends on cco_pkg; feeds cco_queue.
module cco_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [cco_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [cco_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [9:0]                   s_pixel_x,
    input  logic [9:0]                   s_pixel_y,
    input  logic [7:0]                   s_color_in,
    input  logic [7:0]                   s_image_index,
    input  logic [7:0]                   s_image_value,
    input  logic signed [15:0]           s_move_dx,
    input  logic signed [15:0]           s_move_dy,
    input  logic                         q_full,
    output logic                         q_push,
    output cco_pkg::entry_t              q_entry
);

    logic [cco_pkg::SCR_W-1:0]   scr_w_reg, scr_h_reg;
    logic [cco_pkg::CUR_SW-1:0]  cur_w_reg, cur_h_reg;
    logic [cco_pkg::COORD_W-1:0] pos_x_reg, pos_x_next;
    logic [cco_pkg::COORD_W-1:0] pos_y_reg, pos_y_next;

    logic [cco_pkg::SCR_W-1:0]   sw_eff, sh_eff;
    logic [cco_pkg::COORD_W-1:0] sw_m1, sh_m1;
    logic [cco_pkg::CUR_SW-1:0]  cw_eff, ch_eff;
    logic [cco_pkg::COORD_W-1:0] dx, dy;
    logic                        on_screen, in_x, in_y;
    logic [cco_pkg::ASUM_W-1:0]  addr_sum;
    logic signed [cco_pkg::MV_W-1:0] sum_x, sum_y;
    logic [cco_pkg::COORD_W-1:0] nx, ny;
    logic                        accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= cco_pkg::SCREEN_WIDTH_RST;
            scr_h_reg <= cco_pkg::SCREEN_HEIGHT_RST;
            cur_w_reg <= cco_pkg::CURSOR_WIDTH_RST;
            cur_h_reg <= cco_pkg::CURSOR_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                cco_pkg::REG_SCREEN_WIDTH:  scr_w_reg <= cfg_wdata;
                cco_pkg::REG_SCREEN_HEIGHT: scr_h_reg <= cfg_wdata;
                cco_pkg::REG_CURSOR_WIDTH:  cur_w_reg <= cfg_wdata[cco_pkg::CUR_SW-1:0];
                cco_pkg::REG_CURSOR_HEIGHT: cur_h_reg <= cfg_wdata[cco_pkg::CUR_SW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Saturate sizes into their legal ranges
    always_comb begin
        if (scr_w_reg == '0)
            sw_eff = cco_pkg::SCR_W'(1);
        else if (scr_w_reg > cco_pkg::SCR_W'(cco_pkg::COORD_LIMIT))
            sw_eff = cco_pkg::SCR_W'(cco_pkg::COORD_LIMIT);
        else
            sw_eff = scr_w_reg;
        if (scr_h_reg == '0)
            sh_eff = cco_pkg::SCR_W'(1);
        else if (scr_h_reg > cco_pkg::SCR_W'(cco_pkg::COORD_LIMIT))
            sh_eff = cco_pkg::SCR_W'(cco_pkg::COORD_LIMIT);
        else
            sh_eff = scr_h_reg;
        cw_eff = (cur_w_reg > cco_pkg::CUR_SW'(cco_pkg::CURSOR_MAX)) ?
                 cco_pkg::CUR_SW'(cco_pkg::CURSOR_MAX) : cur_w_reg;
        ch_eff = (cur_h_reg > cco_pkg::CUR_SW'(cco_pkg::CURSOR_MAX)) ?
                 cco_pkg::CUR_SW'(cco_pkg::CURSOR_MAX) : cur_h_reg;
    end

    assign sw_m1 = cco_pkg::COORD_W'(sw_eff - cco_pkg::SCR_W'(1));
    assign sh_m1 = cco_pkg::COORD_W'(sh_eff - cco_pkg::SCR_W'(1));

    // Pixel classification
    assign dx        = s_pixel_x - pos_x_reg;
    assign dy        = s_pixel_y - pos_y_reg;
    assign on_screen = (cco_pkg::SCR_W'(s_pixel_x) < sw_eff) &&
                       (cco_pkg::SCR_W'(s_pixel_y) < sh_eff);
    assign in_x      = (s_pixel_x >= pos_x_reg) && (dx < cco_pkg::COORD_W'(cw_eff));
    assign in_y      = (s_pixel_y >= pos_y_reg) && (dy < cco_pkg::COORD_W'(ch_eff));
    assign addr_sum  = cco_pkg::ASUM_W'(dy[cco_pkg::CUR_IW-1:0]) *
                       cco_pkg::ASUM_W'(cw_eff) +
                       cco_pkg::ASUM_W'(dx[cco_pkg::CUR_IW-1:0]);

    // Motion: signed add, then clamp to 0..size-1
    assign sum_x = $signed(cco_pkg::MV_W'(pos_x_reg)) + cco_pkg::MV_W'(s_move_dx);
    assign sum_y = $signed(cco_pkg::MV_W'(pos_y_reg)) + cco_pkg::MV_W'(s_move_dy);

    always_comb begin
        if (sum_x < 0)
            nx = '0;
        else if (sum_x > $signed(cco_pkg::MV_W'(sw_m1)))
            nx = sw_m1;
        else
            nx = cco_pkg::COORD_W'(sum_x);
        if (sum_y < 0)
            ny = '0;
        else if (sum_y > $signed(cco_pkg::MV_W'(sh_m1)))
            ny = sh_m1;
        else
            ny = cco_pkg::COORD_W'(sum_y);
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        q_push         = 1'b0;
        q_entry.kind   = cco_pkg::EK_PIXEL;
        q_entry.hit    = on_screen && in_x && in_y;
        q_entry.addr   = cco_pkg::IMG_AW'(addr_sum);
        q_entry.color  = s_color_in;
        q_entry.cur_x  = nx;
        q_entry.cur_y  = ny;
        q_entry.moved  = (nx != pos_x_reg) || (ny != pos_y_reg);
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        case (s_operation)
            cco_pkg::OP_PIXEL: begin
                q_push = accept;
            end
            cco_pkg::OP_LOAD: begin
                q_push        = accept;
                q_entry.kind  = cco_pkg::EK_LOAD;
                q_entry.addr  = cco_pkg::IMG_AW'(s_image_index);
                q_entry.color = s_image_value;
            end
            cco_pkg::OP_MOVE: begin
                q_push       = accept;
                q_entry.kind = cco_pkg::EK_REPORT;
                if (accept) begin
                    pos_x_next = nx;
                    pos_y_next = ny;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

endmodule

/* hw/rtl/cco_queue.sv */
// Short FIFO of classified items between front and back.
// Depends on cco_pkg for the entry type and depth.
module cco_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cco_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output cco_pkg::entry_t  head_entry
);

    cco_pkg::entry_t           mem_reg [cco_pkg::Q_DEPTH];
    logic [cco_pkg::Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [cco_pkg::Q_AW:0]    count_reg, count_next;

    assign full       = (count_reg == (cco_pkg::Q_AW+1)'(cco_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/cco_back.sv */
// Back end: cursor image store, compositing and the output register.
// Depends on cco_pkg; drains cco_queue.
module cco_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  cco_pkg::entry_t  q_entry,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_result_kind,
    output logic [7:0]       m_color_out,
    output logic [9:0]       m_cursor_x,
    output logic [9:0]       m_cursor_y,
    output logic             m_cursor_moved
);

    logic [7:0]                  img_mem [cco_pkg::IMG_ENTRIES];
    logic [cco_pkg::IMG_ENTRIES-1:0] img_vld_reg;
    logic [7:0]                  img_rd_reg;
    logic                        s1_ivld_reg;
    logic                        s1_valid_reg;
    cco_pkg::entry_t             s1_ent_reg;
    logic                        m_valid_reg;
    logic                        m_kind_reg;
    logic [7:0]                  m_color_reg;
    logic [9:0]                  m_x_reg, m_y_reg;
    logic                        m_moved_reg;
    logic                        s1_adv, s1_free, is_load;
    logic [7:0]                  pix_color;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s1_free = !s1_valid_reg || s1_adv;
    assign q_pop   = q_valid && s1_free;
    assign is_load = (q_entry.kind == cco_pkg::EK_LOAD);

    // Image store; unwritten entries read as transparent via the valid bits
    always_ff @(posedge aclk) begin
        if (q_pop && is_load)
            img_mem[q_entry.addr] <= q_entry.color;
        if (q_pop)
            img_rd_reg <= img_mem[q_entry.addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            img_vld_reg <= '0;
        else if (q_pop && is_load)
            img_vld_reg[q_entry.addr] <= 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_ent_reg  <= q_entry;
            s1_ivld_reg <= img_vld_reg[q_entry.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= q_pop && !is_load;
    end

    assign pix_color = (s1_ent_reg.hit && s1_ivld_reg && img_rd_reg != 8'd0) ?
                       img_rd_reg : s1_ent_reg.color;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            if (s1_ent_reg.kind == cco_pkg::EK_REPORT) begin
                m_kind_reg  <= cco_pkg::RK_REPORT;
                m_color_reg <= '0;
                m_x_reg     <= s1_ent_reg.cur_x;
                m_y_reg     <= s1_ent_reg.cur_y;
                m_moved_reg <= s1_ent_reg.moved;
            end else begin
                m_kind_reg  <= cco_pkg::RK_PIXEL;
                m_color_reg <= pix_color;
                m_x_reg     <= '0;
                m_y_reg     <= '0;
                m_moved_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (s1_adv)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_color_out    = m_color_reg;
    assign m_cursor_x     = m_x_reg;
    assign m_cursor_y     = m_y_reg;
    assign m_cursor_moved = m_moved_reg;

endmodule

/* hw/rtl/cursor_overlay_compositor.sv */
// Cursor overlay compositor, top level: front, queue and back.
// Depends on cco_pkg, cco_front, cco_queue and cco_back.
//
// Items enter on the s_ channel (valid/ready). A pixel item returns one
// composited pixel; a motion item updates the cursor position and returns a
// position report; a load item writes one cursor image entry and returns
// nothing. Results leave on the m_ channel (valid/ready) in input order.
// Registers 0..3 (screen width/height, cursor width/height) are written by the
// user through cfg_we/cfg_index/cfg_wdata only while no item is in flight; the
// block does not enforce this. A pixel or motion item is registered in the
// 4-entry queue, then in stage 1 and in the output register. One item per
// cycle is sustained while m_ready holds. The input keeps taking items while
// the receiver stalls until the queue fills, then s_ready drops. Reset clears
// the position, restores the default sizes and marks every image entry
// transparent at once; items are taken right after.
module cursor_overlay_compositor (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [cco_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [cco_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [9:0]                   s_pixel_x,
    input  logic [9:0]                   s_pixel_y,
    input  logic [7:0]                   s_color_in,
    input  logic [7:0]                   s_image_index,
    input  logic [7:0]                   s_image_value,
    input  logic signed [15:0]           s_move_dx,
    input  logic signed [15:0]           s_move_dy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_result_kind,
    output logic [7:0]                   m_color_out,
    output logic [9:0]                   m_cursor_x,
    output logic [9:0]                   m_cursor_y,
    output logic                         m_cursor_moved
);

    logic            q_push, q_full, q_pop, q_valid;
    cco_pkg::entry_t q_in, q_head;

    cco_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_color_in    (s_color_in),
        .s_image_index (s_image_index),
        .s_image_value (s_image_value),
        .s_move_dx     (s_move_dx),
        .s_move_dy     (s_move_dy),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    cco_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    cco_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_entry        (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_color_out    (m_color_out),
        .m_cursor_x     (m_cursor_x),
        .m_cursor_y     (m_cursor_y),
        .m_cursor_moved (m_cursor_moved)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    a_report_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == cco_pkg::RK_REPORT) |-> m_color_out == 8'd0)
        else $error("position report carries a color");

    a_pixel_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == cco_pkg::RK_PIXEL) |->
        (m_cursor_x == 10'd0 && m_cursor_y == 10'd0 && !m_cursor_moved))
        else $error("pixel result carries position fields");

endmodule
